### rtl/core/rfpclm_pkg.sv
// Shared constants, register indexes and request codes for the pulse code
// learn and match block. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rfpclm_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int TIMING_BITS_DEF  = 16;

    localparam int MIN_VALID_PULSE  = 5;

    localparam int TOL_W       = 8;
    localparam int EDGE_W      = 7;
    localparam int SYNC_W      = 16;
    localparam int PULSE_W     = 16;
    localparam int LEN_W       = 7;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TOL_FIRST    = 3'd0,
        CFG_TOL_REST     = 3'd1,
        CFG_MIN_EDGES    = 3'd2,
        CFG_SYNC_FLOOR   = 3'd3,
        CFG_SYNC_CEILING = 3'd4
    } cfg_index_t;

    localparam logic REQ_PULSE = 1'b0;
    localparam logic REQ_LEARN = 1'b1;

    localparam logic [TOL_W-1:0]  TOL_FIRST_RST    = 8'd26;
    localparam logic [TOL_W-1:0]  TOL_REST_RST     = 8'd51;
    localparam logic [EDGE_W-1:0] MIN_EDGES_RST    = 7'd24;
    localparam logic [SYNC_W-1:0] SYNC_FLOOR_RST   = 16'd0;
    localparam logic [SYNC_W-1:0] SYNC_CEILING_RST = 16'hFFFF;

endpackage

`default_nettype wire

### rtl/core/rfpclm_code_mem.sv
// Code store, used by the top level as two banks: one write port and one
// read port with registered read data. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module rfpclm_code_mem #(
    parameter int DEPTH  = 128,
    parameter int DATA_W = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/rf_pulse_code_learn_match.sv
// Top level of the RF pulse code learn and match block: request pipeline,
// window arithmetic and result register. Depends on rfpclm_pkg and
// rfpclm_code_mem.
//
// Each input request carries one pulse duration of a received frame, with
// frame_end on the last one, or (req_type learn) a command to learn the next
// frame. Only a request with frame_end and req_type pulse gives a result.
// Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_data in a single cycle and must only change while the block is idle.
// The pipeline has three steps: the code store is read on acceptance, the
// tolerance product is formed in the first stage and the window compare
// in the second stage, whose result is loaded into the output register.
// One request is taken per cycle while in_ready is high; the single store
// read port and the multiplier each serve one request a cycle. After
// reset the stored code is empty, so every frame matches, the sync window
// reads zero and the store contents are undefined; no clearing pass is
// run. When the receiver stalls, requests keep flowing until a result is
// held in the final stage behind a full output register and a request
// waits in the first stage; then in_ready falls until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module rf_pulse_code_learn_match #(
    parameter int BUFFER_DEPTH = rfpclm_pkg::BUFFER_DEPTH_DEF,
    parameter int TIMING_BITS  = rfpclm_pkg::TIMING_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [rfpclm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rfpclm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [rfpclm_pkg::PULSE_W-1:0]     pulse_len,
    input  logic                               frame_end,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               matched,
    output logic                               learned,
    output logic [rfpclm_pkg::LEN_W-1:0]       code_length,
    output logic [rfpclm_pkg::SYNC_W-1:0]      sync_low,
    output logic [rfpclm_pkg::SYNC_W-1:0]      sync_high
);

    import rfpclm_pkg::*;

    localparam int AW  = $clog2(BUFFER_DEPTH);
    localparam int PW  = $clog2(BUFFER_DEPTH + 1);
    localparam int TB  = TIMING_BITS;
    localparam int CW  = ((TB > SYNC_W) ? TB : SYNC_W) + 1;
    localparam int EW  = (PW > EDGE_W) ? PW : EDGE_W;
    localparam int MW  = TB + TOL_W;

    // Configuration registers.
    logic [TOL_W-1:0]  tol_first_reg;
    logic [TOL_W-1:0]  tol_rest_reg;
    logic [EDGE_W-1:0] min_edges_reg;
    logic [SYNC_W-1:0] sync_floor_reg;
    logic [SYNC_W-1:0] sync_ceiling_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_first_reg    <= TOL_FIRST_RST;
            tol_rest_reg     <= TOL_REST_RST;
            min_edges_reg    <= MIN_EDGES_RST;
            sync_floor_reg   <= SYNC_FLOOR_RST;
            sync_ceiling_reg <= SYNC_CEILING_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TOL_FIRST:    tol_first_reg    <= cfg_data[TOL_W-1:0];
                CFG_TOL_REST:     tol_rest_reg     <= cfg_data[TOL_W-1:0];
                CFG_MIN_EDGES:    min_edges_reg    <= cfg_data[EDGE_W-1:0];
                CFG_SYNC_FLOOR:   sync_floor_reg   <= cfg_data[SYNC_W-1:0];
                CFG_SYNC_CEILING: sync_ceiling_reg <= cfg_data[SYNC_W-1:0];
                default:          ;
            endcase
        end
    end

    // Frame state, updated as each request is accepted.
    logic          learning_reg,     learning_next;
    logic          active_bank_reg,  active_bank_next;
    logic [PW-1:0] stored_len_reg,   stored_len_next;
    logic [PW-1:0] frame_pos_reg,    frame_pos_next;
    logic          short_seen_reg,   short_seen_next;
    logic [TB-1:0] first_pulse_reg,  first_pulse_next;

    logic          s1_go;
    logic          in_acc;
    logic          is_learn_req;
    logic [31:0]   pulse_ext;
    logic [TB-1:0] pulse_w;
    logic          in_buf;
    logic [PW-1:0] pos_inc;
    logic          check;
    logic          short_all;
    logic [TB-1:0] first_now;
    logic          learn_ok;
    logic          tail_miss;

    assign in_ready     = s1_go;
    assign in_acc       = in_valid && in_ready;
    assign is_learn_req = (req_type == REQ_LEARN);
    assign pulse_ext    = 32'(pulse_len);
    assign pulse_w      = pulse_ext[TB-1:0];
    assign in_buf       = (frame_pos_reg < PW'(BUFFER_DEPTH));
    assign pos_inc      = in_buf ? (frame_pos_reg + PW'(1)) : frame_pos_reg;
    assign check        = !learning_reg && in_buf && (frame_pos_reg < stored_len_reg);
    assign short_all    = short_seen_reg
                          || (learning_reg && in_buf && (pulse_w < TB'(MIN_VALID_PULSE)));
    assign first_now    = (learning_reg && in_buf && (frame_pos_reg == '0)) ?
                          pulse_w : first_pulse_reg;
    assign learn_ok     = learning_reg && frame_end && !short_all
                          && (EW'(pos_inc) >= EW'(min_edges_reg));
    assign tail_miss    = !learning_reg && (pos_inc < stored_len_reg);

    always_comb
    begin
        learning_next    = learning_reg;
        active_bank_next = active_bank_reg;
        stored_len_next  = stored_len_reg;
        frame_pos_next   = frame_pos_reg;
        short_seen_next  = short_seen_reg;
        first_pulse_next = first_pulse_reg;
        if (in_acc)
        begin
            if (is_learn_req)
            begin
                learning_next   = 1'b1;
                frame_pos_next  = '0;
                short_seen_next = 1'b0;
            end
            else
            begin
                first_pulse_next = first_now;
                if (frame_end)
                begin
                    frame_pos_next  = '0;
                    short_seen_next = 1'b0;
                    if (learn_ok)
                    begin
                        learning_next    = 1'b0;
                        active_bank_next = !active_bank_reg;
                        stored_len_next  = pos_inc;
                    end
                end
                else
                begin
                    frame_pos_next  = pos_inc;
                    short_seen_next = short_all;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learning_reg    <= 1'b0;
            active_bank_reg <= 1'b0;
            stored_len_reg  <= '0;
            frame_pos_reg   <= '0;
            short_seen_reg  <= 1'b0;
            first_pulse_reg <= '0;
        end
        else
        begin
            learning_reg    <= learning_next;
            active_bank_reg <= active_bank_next;
            stored_len_reg  <= stored_len_next;
            frame_pos_reg   <= frame_pos_next;
            short_seen_reg  <= short_seen_next;
            first_pulse_reg <= first_pulse_next;
        end
    end

    // Learning writes the inactive bank and matching reads the active one,
    // so a read and a write in the same cycle never meet at one entry.
    logic          mem_wr_en;
    logic          mem_rd_en;
    logic [AW:0]   mem_wr_addr;
    logic [AW:0]   mem_rd_addr;
    logic [TB-1:0] mem_rd_data;

    assign mem_wr_en   = in_acc && !is_learn_req && learning_reg && in_buf;
    assign mem_rd_en   = in_acc && !is_learn_req && check;
    assign mem_wr_addr = {!active_bank_reg, frame_pos_reg[AW-1:0]};
    assign mem_rd_addr = {active_bank_reg, frame_pos_reg[AW-1:0]};

    rfpclm_code_mem #(
        .DEPTH  (2 ** (AW + 1)),
        .DATA_W (TB)
    ) u_code_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (pulse_w),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // First stage: store read data arrives and the tolerance product is formed.
    logic             s1_valid_reg;
    logic             s1_check_reg;
    logic             s1_clr_reg;
    logic             s1_res_reg;
    logic             s1_learned_reg;
    logic             s1_run_reg;
    logic             s1_tail_reg;
    logic [TB-1:0]    s1_pulse_reg;
    logic [TB-1:0]    s1_first_reg;
    logic [TOL_W-1:0] s1_tol_reg;
    logic [LEN_W-1:0] s1_len_reg;

    logic             s2_go;

    assign s1_go = !s1_valid_reg || s2_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_check_reg   <= !is_learn_req && check;
            s1_clr_reg     <= is_learn_req || frame_end;
            s1_res_reg     <= !is_learn_req && frame_end;
            s1_learned_reg <= !is_learn_req && learn_ok;
            s1_run_reg     <= !learning_reg;
            s1_tail_reg    <= tail_miss;
            s1_pulse_reg   <= pulse_w;
            s1_first_reg   <= first_now;
            s1_tol_reg     <= (check && (frame_pos_reg != '0)) ? tol_rest_reg : tol_first_reg;
            s1_len_reg     <= LEN_W'(learn_ok ? pos_inc : stored_len_reg);
        end
    end

    logic [TB-1:0] mul_a;
    logic [MW-1:0] product;

    assign mul_a   = s1_learned_reg ? s1_first_reg : mem_rd_data;
    assign product = MW'(mul_a) * MW'(s1_tol_reg);

    // Second stage: window compare, sync clamp and mismatch accumulation.
    logic             s2_valid_reg;
    logic             s2_check_reg;
    logic             s2_clr_reg;
    logic             s2_res_reg;
    logic             s2_learned_reg;
    logic             s2_run_reg;
    logic             s2_tail_reg;
    logic [TB-1:0]    s2_pulse_reg;
    logic [TB-1:0]    s2_s_reg;
    logic [TB-1:0]    s2_delta_reg;
    logic [LEN_W-1:0] s2_len_reg;

    logic out_free;

    assign out_free = !out_valid || out_ready;
    assign s2_go    = !s2_valid_reg || !s2_res_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_go)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go && s1_valid_reg)
        begin
            s2_check_reg   <= s1_check_reg;
            s2_clr_reg     <= s1_clr_reg;
            s2_res_reg     <= s1_res_reg;
            s2_learned_reg <= s1_learned_reg;
            s2_run_reg     <= s1_run_reg;
            s2_tail_reg    <= s1_tail_reg;
            s2_pulse_reg   <= s1_pulse_reg;
            s2_s_reg       <= mul_a;
            s2_delta_reg   <= product[MW-1:TOL_W];
            s2_len_reg     <= s1_len_reg;
        end
    end

    logic              s2_fire;
    logic [TB-1:0]     win_lo;
    logic [TB:0]       win_hi;
    logic              miss;
    logic              mism_acc_reg, mism_acc_next;
    logic              match_val;
    logic [CW-1:0]     lo_clamp;
    logic [CW-1:0]     hi_clamp;
    logic [SYNC_W-1:0] sync_low_reg,  sync_low_next;
    logic [SYNC_W-1:0] sync_high_reg, sync_high_next;

    assign s2_fire   = s2_valid_reg && s2_go;
    assign win_lo    = s2_s_reg - s2_delta_reg;
    assign win_hi    = {1'b0, s2_s_reg} + {1'b0, s2_delta_reg};
    assign miss      = s2_check_reg
                       && ((s2_pulse_reg < win_lo) || ({1'b0, s2_pulse_reg} > win_hi));
    assign match_val = s2_run_reg && !(mism_acc_reg || miss || s2_tail_reg);
    assign lo_clamp  = (CW'(win_lo) < CW'(sync_floor_reg)) ?
                       CW'(sync_floor_reg) : CW'(win_lo);
    assign hi_clamp  = (CW'(win_hi) > CW'(sync_ceiling_reg)) ?
                       CW'(sync_ceiling_reg) : CW'(win_hi);

    always_comb
    begin
        mism_acc_next  = mism_acc_reg;
        sync_low_next  = sync_low_reg;
        sync_high_next = sync_high_reg;
        if (s2_fire)
        begin
            mism_acc_next = s2_clr_reg ? 1'b0 : (mism_acc_reg || miss);
            if (s2_learned_reg)
            begin
                sync_low_next  = lo_clamp[SYNC_W-1:0];
                sync_high_next = hi_clamp[SYNC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mism_acc_reg  <= 1'b0;
            sync_low_reg  <= '0;
            sync_high_reg <= '0;
        end
        else
        begin
            mism_acc_reg  <= mism_acc_next;
            sync_low_reg  <= sync_low_next;
            sync_high_reg <= sync_high_next;
        end
    end

    // Output register.
    logic              out_valid_reg;
    logic              matched_reg;
    logic              learned_reg;
    logic [LEN_W-1:0]  code_length_reg;
    logic [SYNC_W-1:0] out_sync_low_reg;
    logic [SYNC_W-1:0] out_sync_high_reg;
    logic              out_load;

    assign out_load = s2_valid_reg && s2_res_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            matched_reg       <= match_val;
            learned_reg       <= s2_learned_reg;
            code_length_reg   <= s2_len_reg;
            out_sync_low_reg  <= sync_low_next;
            out_sync_high_reg <= sync_high_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign matched     = matched_reg;
    assign learned     = learned_reg;
    assign code_length = code_length_reg;
    assign sync_low    = out_sync_low_reg;
    assign sync_high   = out_sync_high_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        frame_pos_reg <= PW'(BUFFER_DEPTH))
        else $error("frame position ran past the buffer depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(matched_reg && learned_reg))
        else $error("a result reports both a match and a learned code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (req_type == REQ_LEARN)) |=> (learning_reg && (frame_pos_reg == '0)))
        else $error("learn request did not restart the frame in learn mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !is_learn_req && learn_ok)
        |=> (!learning_reg && (active_bank_reg != $past(active_bank_reg))))
        else $error("a learned frame did not swap the code bank");

endmodule

`default_nettype wire
